// ----- hw/rtl/ille_pkg.sv -----
// Shared types, codes and defaults for the indexed linked list engine.
`timescale 1ns / 1ps

package ille_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Operation codes carried in the mode field.
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_INSERT     = 3'd3;
  localparam mode_t MODE_ERASE      = 3'd4;
  localparam mode_t MODE_CLEAR      = 3'd5;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef struct packed {
    mode_t  mode;
    pos_t   position;
    value_t value;
  } req_t;

  typedef struct packed {
    status_t status;
    value_t  front_value;
    value_t  back_value;
    count_t  count;
    logic    is_empty;
  } rsp_t;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [4:0] {
    UOP_IDLE,
    UOP_LOAD,
    UOP_CLEAR,
    UOP_ALLOC,
    UOP_ALLOC_FIX,
    UOP_LINK_FRONT,
    UOP_LINK_BACK,
    UOP_CLOSE,
    UOP_WALK_INIT,
    UOP_WALK,
    UOP_ERA_VICTIM,
    UOP_ERA_LINK,
    UOP_INS_LINK,
    UOP_INS_PREV,
    UOP_POP_READ,
    UOP_POP_ADV,
    UOP_POP_FRONT,
    UOP_DROP_ONE,
    UOP_RELEASE,
    UOP_RESULT
  } uop_t;

  typedef struct packed {
    uop_t    uop;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  cnt_zero;
    logic  cnt_one;
    logic  can_alloc;
    logic  pos_zero;
    logic  pos_gt_cnt;
    logic  pos_eq_cnt;
    logic  walk_done;
    logic  out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/ille_dp.sv -----
// Datapath: node store, list pointers, free list, walk pointer and result register.
`timescale 1ns / 1ps

module ille_dp #(
  parameter int CAPACITY   = ille_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ille_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ille_pkg::req_t     request,
  output ille_pkg::rsp_t     result,
  output logic               result_valid,
  input  logic               result_ready,
  input  ille_pkg::dp_cmd_t  cmd,
  output ille_pkg::dp_stat_t stat
);

  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ille_pkg::POS_W) ? CW : ille_pkg::POS_W;

  typedef logic [SW-1:0] slot_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [CMPW-1:0] cmp_t;

  slot_t link_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];

  slot_t head, tail, free_head, cur, nslot, victim, link_q;
  cnt_t  cnt, fresh, free_cnt;
  logic  took_free;
  ille_pkg::mode_t  op_mode;
  ille_pkg::pos_t   op_pos, steps;
  logic [DATA_WIDTH-1:0] op_val, front, back, val_q;
  ille_pkg::rsp_t   out_reg;
  logic             out_valid;

  logic  lw_en, lr_en, vw_en, vr_en;
  slot_t lw_addr, lw_data, lr_addr, vr_addr, alloc_sel;
  logic  take_free, cnt_zero, walk_done;

  assign take_free = (free_cnt != '0);
  assign alloc_sel = take_free ? free_head : fresh[SW-1:0];
  assign cnt_zero  = (cnt == '0);
  assign walk_done = (steps == '0);

  assign stat.mode       = op_mode;
  assign stat.cnt_zero   = cnt_zero;
  assign stat.cnt_one    = (cnt == cnt_t'(1));
  assign stat.can_alloc  = take_free || (fresh < cnt_t'(CAPACITY));
  assign stat.pos_zero   = (op_pos == '0);
  assign stat.pos_gt_cnt = (cmp_t'(op_pos) > cmp_t'(cnt));
  assign stat.pos_eq_cnt = (cmp_t'(op_pos) == cmp_t'(cnt));
  assign stat.walk_done  = walk_done;
  assign stat.out_free   = !out_valid || result_ready;

  assign result       = out_reg;
  assign result_valid = out_valid;

  // Memory port steering per micro-operation.
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = tail;
    lw_data = head;
    lr_en   = 1'b0;
    lr_addr = head;
    vw_en   = 1'b0;
    vr_en   = 1'b0;
    vr_addr = cur;
    case (cmd.uop)
      ille_pkg::UOP_ALLOC: begin
        vw_en   = 1'b1;
        lr_en   = 1'b1;
        lr_addr = free_head;
      end
      ille_pkg::UOP_LINK_FRONT: begin
        lw_en   = 1'b1;
        lw_addr = nslot;
        lw_data = cnt_zero ? nslot : head;
      end
      ille_pkg::UOP_LINK_BACK: begin
        lw_en   = 1'b1;
        lw_addr = cnt_zero ? nslot : tail;
        lw_data = nslot;
      end
      ille_pkg::UOP_CLOSE: begin
        lw_en = 1'b1;
      end
      ille_pkg::UOP_WALK_INIT, ille_pkg::UOP_POP_READ: begin
        lr_en = 1'b1;
      end
      ille_pkg::UOP_WALK: begin
        lr_en   = !walk_done;
        lr_addr = link_q;
      end
      ille_pkg::UOP_ERA_VICTIM: begin
        lr_en   = 1'b1;
        lr_addr = link_q;
        vr_en   = 1'b1;
      end
      ille_pkg::UOP_ERA_LINK: begin
        lw_en   = 1'b1;
        lw_addr = cur;
        lw_data = link_q;
      end
      ille_pkg::UOP_INS_LINK: begin
        lw_en   = 1'b1;
        lw_addr = nslot;
        lw_data = link_q;
      end
      ille_pkg::UOP_INS_PREV: begin
        lw_en   = 1'b1;
        lw_addr = cur;
        lw_data = nslot;
      end
      ille_pkg::UOP_POP_ADV: begin
        vr_en   = 1'b1;
        vr_addr = link_q;
      end
      ille_pkg::UOP_RELEASE: begin
        lw_en   = 1'b1;
        lw_addr = victim;
        lw_data = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (lr_en) begin
      link_q <= link_mem[lr_addr];
    end
    if (vw_en) begin
      val_mem[alloc_sel] <= op_val;
    end
    if (vr_en) begin
      val_q <= val_mem[vr_addr];
    end
  end

  // Control registers: pointers, counts and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      fresh     <= '0;
      free_head <= '0;
      free_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.uop == ille_pkg::UOP_RESULT) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.uop)
        ille_pkg::UOP_CLEAR: begin
          head      <= '0;
          tail      <= '0;
          cnt       <= '0;
          fresh     <= '0;
          free_head <= '0;
          free_cnt  <= '0;
        end
        ille_pkg::UOP_ALLOC: begin
          if (take_free) begin
            free_cnt <= free_cnt - cnt_t'(1);
          end else begin
            fresh <= fresh + cnt_t'(1);
          end
        end
        ille_pkg::UOP_ALLOC_FIX: begin
          if (took_free) begin
            free_head <= link_q;
          end
        end
        ille_pkg::UOP_LINK_FRONT: begin
          head <= nslot;
          if (cnt_zero) begin
            tail <= nslot;
          end
          cnt <= cnt + cnt_t'(1);
        end
        ille_pkg::UOP_LINK_BACK: begin
          tail <= nslot;
          if (cnt_zero) begin
            head <= nslot;
          end
          cnt <= cnt + cnt_t'(1);
        end
        ille_pkg::UOP_ERA_VICTIM: begin
          if (link_q == tail) begin
            tail <= cur;
          end
        end
        ille_pkg::UOP_INS_PREV: begin
          cnt <= cnt + cnt_t'(1);
        end
        ille_pkg::UOP_POP_ADV: begin
          head <= link_q;
        end
        ille_pkg::UOP_DROP_ONE: begin
          head <= '0;
          tail <= '0;
        end
        ille_pkg::UOP_RELEASE: begin
          free_head <= victim;
          free_cnt  <= free_cnt + cnt_t'(1);
          cnt       <= cnt - cnt_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: latched request, walk state, end values, result.
  always_ff @(posedge clk) begin
    case (cmd.uop)
      ille_pkg::UOP_LOAD: begin
        op_mode <= request.mode;
        op_pos  <= request.position;
        op_val  <= DATA_WIDTH'(request.value);
      end
      ille_pkg::UOP_ALLOC: begin
        nslot     <= alloc_sel;
        took_free <= take_free;
      end
      ille_pkg::UOP_LINK_FRONT: begin
        front <= op_val;
        if (cnt_zero) begin
          back <= op_val;
        end
      end
      ille_pkg::UOP_LINK_BACK: begin
        back <= op_val;
        if (cnt_zero) begin
          front <= op_val;
        end
      end
      ille_pkg::UOP_WALK_INIT: begin
        cur   <= head;
        steps <= op_pos - ille_pkg::pos_t'(1);
      end
      ille_pkg::UOP_WALK: begin
        if (!walk_done) begin
          cur   <= link_q;
          steps <= steps - ille_pkg::pos_t'(1);
        end
      end
      ille_pkg::UOP_ERA_VICTIM: begin
        victim <= link_q;
      end
      ille_pkg::UOP_ERA_LINK: begin
        if (tail == cur) begin
          back <= val_q;
        end
      end
      ille_pkg::UOP_POP_READ, ille_pkg::UOP_DROP_ONE: begin
        victim <= head;
      end
      ille_pkg::UOP_POP_FRONT: begin
        front <= val_q;
      end
      ille_pkg::UOP_RESULT: begin
        out_reg.status      <= cmd.status;
        out_reg.front_value <= cnt_zero ? '0 : ille_pkg::value_t'(front);
        out_reg.back_value  <= cnt_zero ? '0 : ille_pkg::value_t'(back);
        out_reg.count       <= ille_pkg::count_t'(cnt);
        out_reg.is_empty    <= cnt_zero;
      end
      default: begin
      end
    endcase
  end

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.uop == ille_pkg::UOP_RESULT |-> (!out_valid || result_ready))
    else $error("result loaded over an unaccepted result");

  a_slot_conservation: assert property (@(posedge clk) disable iff (rst)
    cmd.uop == ille_pkg::UOP_RESULT |->
      ({1'b0, cnt} + {1'b0, free_cnt}) == {1'b0, fresh})
    else $error("live plus free slots differ from slots handed out");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == ille_pkg::UOP_RESULT && cnt_zero) |-> (head == '0 && tail == '0))
    else $error("empty list with nonzero head or tail");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.uop == ille_pkg::UOP_RESULT |-> cnt <= cnt_t'(CAPACITY))
    else $error("element count above capacity");

endmodule

// ----- hw/rtl/ille_ctrl.sv -----
// Controller: sequences micro-operations for each list request.
`timescale 1ns / 1ps

module ille_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_ready,
  output ille_pkg::dp_cmd_t  cmd,
  input  ille_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_ALLOC_FIX,
    S_LINK_FRONT,
    S_LINK_BACK,
    S_CLOSE,
    S_WALK_INIT,
    S_WALK,
    S_ERA_VICTIM,
    S_ERA_LINK,
    S_INS_LINK,
    S_INS_PREV,
    S_POP_READ,
    S_POP_ADV,
    S_POP_FRONT,
    S_DROP_ONE,
    S_RELEASE,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    K_FRONT,
    K_BACK,
    K_MID,
    K_ERASE,
    K_POP
  } kind_t;

  state_t state, state_next;
  kind_t  kind, kind_next;
  ille_pkg::status_t status, status_next;

  assign request_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    status_next = status;
    cmd.uop     = ille_pkg::UOP_IDLE;
    cmd.status  = status;
    case (state)
      S_IDLE: begin
        if (request_valid) begin
          cmd.uop    = ille_pkg::UOP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        status_next = ille_pkg::ST_OK;
        state_next  = S_FINISH;
        case (stat.mode)
          ille_pkg::MODE_PUSH_FRONT, ille_pkg::MODE_PUSH_BACK: begin
            kind_next = (stat.mode == ille_pkg::MODE_PUSH_FRONT) ? K_FRONT : K_BACK;
            if (stat.can_alloc) begin
              state_next = S_ALLOC;
            end else begin
              status_next = ille_pkg::ST_FULL;
            end
          end
          ille_pkg::MODE_POP_FRONT: begin
            kind_next = K_POP;
            if (stat.cnt_zero) begin
              status_next = ille_pkg::ST_EMPTY;
            end else begin
              state_next = stat.cnt_one ? S_DROP_ONE : S_POP_READ;
            end
          end
          ille_pkg::MODE_INSERT: begin
            if (stat.pos_gt_cnt) begin
              status_next = ille_pkg::ST_RANGE;
            end else if (!stat.can_alloc) begin
              status_next = ille_pkg::ST_FULL;
            end else begin
              state_next = S_ALLOC;
              if (stat.pos_zero) begin
                kind_next = K_FRONT;
              end else if (stat.pos_eq_cnt) begin
                kind_next = K_BACK;
              end else begin
                kind_next = K_MID;
              end
            end
          end
          ille_pkg::MODE_ERASE: begin
            if (stat.pos_gt_cnt || stat.pos_eq_cnt) begin
              status_next = ille_pkg::ST_RANGE;
            end else if (stat.pos_zero) begin
              kind_next  = K_POP;
              state_next = stat.cnt_one ? S_DROP_ONE : S_POP_READ;
            end else begin
              kind_next  = K_ERASE;
              state_next = S_WALK_INIT;
            end
          end
          ille_pkg::MODE_CLEAR: begin
            cmd.uop = ille_pkg::UOP_CLEAR;
          end
          default: begin
          end
        endcase
      end
      S_ALLOC: begin
        cmd.uop    = ille_pkg::UOP_ALLOC;
        state_next = S_ALLOC_FIX;
      end
      S_ALLOC_FIX: begin
        cmd.uop = ille_pkg::UOP_ALLOC_FIX;
        case (kind)
          K_FRONT: state_next = S_LINK_FRONT;
          K_BACK:  state_next = S_LINK_BACK;
          default: state_next = S_WALK_INIT;
        endcase
      end
      S_LINK_FRONT: begin
        cmd.uop    = ille_pkg::UOP_LINK_FRONT;
        state_next = S_CLOSE;
      end
      S_LINK_BACK: begin
        cmd.uop    = ille_pkg::UOP_LINK_BACK;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.uop    = ille_pkg::UOP_CLOSE;
        state_next = (kind == K_FRONT || kind == K_BACK) ? S_FINISH : S_RELEASE;
      end
      S_WALK_INIT: begin
        cmd.uop    = ille_pkg::UOP_WALK_INIT;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.uop = ille_pkg::UOP_WALK;
        if (stat.walk_done) begin
          state_next = (kind == K_MID) ? S_INS_LINK : S_ERA_VICTIM;
        end
      end
      S_ERA_VICTIM: begin
        cmd.uop    = ille_pkg::UOP_ERA_VICTIM;
        state_next = S_ERA_LINK;
      end
      S_ERA_LINK: begin
        cmd.uop    = ille_pkg::UOP_ERA_LINK;
        state_next = S_CLOSE;
      end
      S_INS_LINK: begin
        cmd.uop    = ille_pkg::UOP_INS_LINK;
        state_next = S_INS_PREV;
      end
      S_INS_PREV: begin
        cmd.uop    = ille_pkg::UOP_INS_PREV;
        state_next = S_FINISH;
      end
      S_POP_READ: begin
        cmd.uop    = ille_pkg::UOP_POP_READ;
        state_next = S_POP_ADV;
      end
      S_POP_ADV: begin
        cmd.uop    = ille_pkg::UOP_POP_ADV;
        state_next = S_POP_FRONT;
      end
      S_POP_FRONT: begin
        cmd.uop    = ille_pkg::UOP_POP_FRONT;
        state_next = S_CLOSE;
      end
      S_DROP_ONE: begin
        cmd.uop    = ille_pkg::UOP_DROP_ONE;
        state_next = S_RELEASE;
      end
      S_RELEASE: begin
        cmd.uop    = ille_pkg::UOP_RELEASE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the result register can take the new result.
        if (stat.out_free) begin
          cmd.uop    = ille_pkg::UOP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind   <= K_FRONT;
      status <= ille_pkg::ST_OK;
    end else begin
      state  <= state_next;
      kind   <= kind_next;
      status <= status_next;
    end
  end

endmodule

// ----- hw/rtl/indexed_linked_list_engine.sv -----
// Top level of the indexed circular linked list engine.
`timescale 1ns / 1ps
//
//   channel   | direction | handshake                     | payload
//   ----------+-----------+-------------------------------+-----------------------------
//   request   | in        | request_valid / request_ready | mode, position, value
//   result    | out       | result_valid / result_ready   | status, front_value,
//             |           |                               | back_value, count, is_empty
//
// Sequencing: one request at a time. Insert and erase inside the list walk the link
//   store one link per cycle through its single read port.
// Reset: synchronous; pointers, counts and handshake state clear at once. The node
//   store is not cleared, since no value read from an unwritten slot is ever used.
// Stalls: a finished result waits in the output register while the next request
//   is taken; the sequencer holds its last step until that register frees.

module indexed_linked_list_engine #(
  parameter int CAPACITY   = ille_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ille_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_ready,
  input  ille_pkg::req_t request,
  output logic           result_valid,
  input  logic           result_ready,
  output ille_pkg::rsp_t result
);

  // Command from the sequencer and status back from the datapath.
  ille_pkg::dp_cmd_t  cmd;
  ille_pkg::dp_stat_t stat;

  // Sequencer: decode each request, step through the list update, post the result.
  ille_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // Datapath: node store, free list, walk pointer, front and back values and
  // the result register that parts the output side from the sequencer.
  ille_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// ----- bench/ille_checker.sv -----
// Request/result monitor holding a list model that predicts and checks every result.
`timescale 1ns / 1ps

module ille_checker
  import ille_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   request_valid,
  input  logic   request_ready,
  input  req_t   request,
  input  logic   result_valid,
  input  logic   result_ready,
  input  rsp_t   result,
  output int     mismatch_count,
  output int     results_outstanding,
  output count_t list_size
);

  localparam int SLOTS = CAPACITY_DEF;

  typedef logic [$clog2(SLOTS)-1:0] slot_t;

  // Node store and list pointers of the model.
  value_t node_value [SLOTS];
  slot_t  node_next  [SLOTS];
  slot_t  head_idx;
  slot_t  tail_idx;
  slot_t  spare_head;
  count_t elem_count;
  count_t fresh_idx;
  count_t spare_count;

  rsp_t expected_results [$];

  function automatic void clear_store();
    head_idx    = '0;
    tail_idx    = '0;
    elem_count  = '0;
    fresh_idx   = '0;
    spare_head  = '0;
    spare_count = '0;
  endfunction

  function automatic bit slot_available();
    return spare_count != 0 || fresh_idx < SLOTS;
  endfunction

  // Reuse a freed slot first, else hand out the next never-used one.
  function automatic slot_t take_slot(value_t v);
    slot_t s;
    if (spare_count != 0) begin
      s = spare_head;
      spare_head = node_next[s];
      spare_count--;
    end else begin
      s = slot_t'(fresh_idx);
      fresh_idx++;
    end
    node_value[s] = v;
    return s;
  endfunction

  function automatic void give_back(slot_t s);
    node_next[s] = spare_head;
    spare_head   = s;
    spare_count++;
  endfunction

  function automatic slot_t slot_at(count_t steps);
    slot_t s;
    s = head_idx;
    for (int i = 0; i < steps; i++) s = node_next[s];
    return s;
  endfunction

  function automatic status_t link_front(value_t v);
    slot_t n;
    if (!slot_available()) return ST_FULL;
    n = take_slot(v);
    if (elem_count == 0) begin
      head_idx = n;
      tail_idx = n;
    end else begin
      node_next[n] = head_idx;
      head_idx = n;
    end
    node_next[tail_idx] = head_idx;
    elem_count++;
    return ST_OK;
  endfunction

  function automatic status_t link_back(value_t v);
    slot_t n;
    if (!slot_available()) return ST_FULL;
    n = take_slot(v);
    if (elem_count == 0) begin
      head_idx = n;
      tail_idx = n;
    end else begin
      node_next[tail_idx] = n;
      tail_idx = n;
    end
    node_next[tail_idx] = head_idx;
    elem_count++;
    return ST_OK;
  endfunction

  function automatic status_t unlink_front();
    slot_t old;
    if (elem_count == 0) return ST_EMPTY;
    old = head_idx;
    if (elem_count == 1) begin
      head_idx = '0;
      tail_idx = '0;
    end else begin
      head_idx = node_next[old];
      node_next[tail_idx] = head_idx;
    end
    give_back(old);
    elem_count--;
    return ST_OK;
  endfunction

  // Index is checked before fullness; the ends fall back to the push paths.
  function automatic status_t insert_at(pos_t pos, value_t v);
    slot_t prev;
    slot_t n;
    if (pos > elem_count) return ST_RANGE;
    if (pos == 0) return link_front(v);
    if (pos == elem_count) return link_back(v);
    if (!slot_available()) return ST_FULL;
    prev = slot_at(count_t'(pos - 1));
    n = take_slot(v);
    node_next[n]    = node_next[prev];
    node_next[prev] = n;
    elem_count++;
    return ST_OK;
  endfunction

  function automatic status_t erase_at(pos_t pos);
    slot_t prev;
    slot_t victim;
    if (pos >= elem_count) return ST_RANGE;
    if (pos == 0) return unlink_front();
    prev   = slot_at(count_t'(pos - 1));
    victim = node_next[prev];
    node_next[prev] = node_next[victim];
    if (victim == tail_idx) tail_idx = prev;
    node_next[tail_idx] = head_idx;
    give_back(victim);
    elem_count--;
    return ST_OK;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t    o;
    status_t st;
    st = ST_OK;
    case (r.mode)
      MODE_PUSH_FRONT: st = link_front(r.value);
      MODE_PUSH_BACK:  st = link_back(r.value);
      MODE_POP_FRONT:  st = unlink_front();
      MODE_INSERT:     st = insert_at(r.position, r.value);
      MODE_ERASE:      st = erase_at(r.position);
      MODE_CLEAR:      clear_store();
      default:         ;
    endcase
    o.status      = st;
    o.front_value = (elem_count == 0) ? '0 : node_value[head_idx];
    o.back_value  = (elem_count == 0) ? '0 : node_value[tail_idx];
    o.count       = elem_count;
    o.is_empty    = (elem_count == 0);
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      clear_store();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // Check the result first; a request taken this edge cannot be answered yet.
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no request waiting", result));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (result.status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      result.status, want.status));
          if (result.front_value !== want.front_value)
            report_mismatch($sformatf("front_value got %h, expected %h",
                                      result.front_value, want.front_value));
          if (result.back_value !== want.back_value)
            report_mismatch($sformatf("back_value got %h, expected %h",
                                      result.back_value, want.back_value));
          if (result.count !== want.count)
            report_mismatch($sformatf("count got %0d, expected %0d",
                                      result.count, want.count));
          if (result.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b, expected %b",
                                      result.is_empty, want.is_empty));
        end
      end
      if (request_valid && request_ready)
        expected_results.insert(expected_results.size(), apply_request(request));
    end
    results_outstanding <= expected_results.size();
    list_size           <= elem_count;
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, request and result traffic, and the pass/fail verdict.
`timescale 1ns / 1ps

module tb_top;
  import ille_pkg::*;

  localparam int CYCLE_LIMIT     = 600_000;
  localparam int HOLD_OFF_CYCLES = 400;
  // Longest walk is about CAPACITY links plus setup; wait well past it at the end.
  localparam int DRAIN_CYCLES    = CAPACITY_DEF + 40;
  localparam int RANDOM_ITEMS    = 560;

  // Mode codes the block does not use; they must leave the list alone.
  localparam mode_t MODE_SPARE_6 = 3'd6;
  localparam mode_t MODE_SPARE_7 = 3'd7;

  logic   clk;
  logic   rst;
  logic   request_valid;
  logic   request_ready;
  req_t   request;
  logic   result_valid;
  logic   result_ready;
  rsp_t   result;

  int     mismatch_count;
  int     results_outstanding;
  count_t list_size;

  int     cycle_count;
  bit     idle_on;
  int     hold_offs_asked;
  int     hold_offs_done;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  indexed_linked_list_engine i_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  ille_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .request_valid       (request_valid),
    .request_ready       (request_ready),
    .request             (request),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .result              (result),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding),
    .list_size           (list_size)
  );

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off whenever one is asked.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && hold_offs_done != hold_offs_asked) begin
        hold_offs_done++;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !(idle_on && $urandom_range(99) < 16);
      end
    end
  end

  function automatic req_t make_req(mode_t m, pos_t p, value_t v);
    req_t r;
    r.mode     = m;
    r.position = p;
    r.value    = v;
    return r;
  endfunction

  // Bias values toward the all-zeros and all-ones extremes.
  function automatic value_t pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until accepted; maybe idle first.
  task automatic send_request(input req_t r);
    while (idle_on && $urandom_range(99) < 16) begin
      @(negedge clk);
      request_valid <= 1'b0;
    end
    @(negedge clk);
    request_valid <= 1'b1;
    request       <= r;
    @(posedge clk);
    while (!request_ready) @(posedge clk);
  endtask

  // Drop valid so the last request is not taken twice, then wait for all results.
  task automatic pause_until_drained();
    @(negedge clk);
    request_valid <= 1'b0;
    while (results_outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    req_t   r;
    count_t size;
    int     sel;

    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    idle_on       = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Errors on an empty list: pop, erase, insert past the end.
    send_request(make_req(MODE_POP_FRONT, '0, '0));
    send_request(make_req(MODE_ERASE, '0, '0));
    send_request(make_req(MODE_INSERT, 7'd1, 32'h1111_1111));

    // Build a short list through every insertion path.
    send_request(make_req(MODE_INSERT, '0, '0));
    send_request(make_req(MODE_PUSH_BACK, '0, '1));
    send_request(make_req(MODE_PUSH_FRONT, 7'd127, 32'h0000_0001));
    send_request(make_req(MODE_INSERT, 7'd1, 32'hA5A5_A5A5));
    send_request(make_req(MODE_INSERT, 7'd4, 32'h5A5A_5A5A));
    send_request(make_req(MODE_INSERT, 7'd127, 32'hDEAD_BEEF));
    send_request(make_req(MODE_ERASE, 7'd64, '0));

    // Erase in the middle, at the tail and at the head.
    send_request(make_req(MODE_ERASE, 7'd2, '0));
    send_request(make_req(MODE_ERASE, 7'd3, '0));
    send_request(make_req(MODE_ERASE, '0, '0));

    // Unused modes leave the list as it is.
    send_request(make_req(MODE_SPARE_6, 7'd64, '1));
    send_request(make_req(MODE_SPARE_7, 7'd127, '1));

    // Pop down to a single element and then to empty, and clear an empty list.
    send_request(make_req(MODE_POP_FRONT, '0, '0));
    send_request(make_req(MODE_POP_FRONT, '0, '0));
    send_request(make_req(MODE_CLEAR, '0, '0));

    // Fill the store from both ends, then hit every full case.
    for (int i = 0; i < CAPACITY_DEF; i++)
      send_request(make_req(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                            pos_t'($urandom), pick_value()));
    send_request(make_req(MODE_PUSH_FRONT, '0, '1));
    send_request(make_req(MODE_PUSH_BACK, '0, '1));
    send_request(make_req(MODE_INSERT, 7'd10, '1));
    send_request(make_req(MODE_INSERT, 7'd64, '1));
    send_request(make_req(MODE_INSERT, '0, '1));
    // Index is judged before fullness.
    send_request(make_req(MODE_INSERT, 7'd65, '1));
    // Erase the tail with the longest walk, then reuse freed slots.
    send_request(make_req(MODE_ERASE, 7'd63, '0));
    send_request(make_req(MODE_INSERT, 7'd30, 32'hCAFE_F00D));
    send_request(make_req(MODE_ERASE, '0, '0));
    send_request(make_req(MODE_INSERT, 7'd63, 32'h8000_0000));
    send_request(make_req(MODE_CLEAR, '0, '0));
    send_request(make_req(MODE_PUSH_BACK, '0, 32'h7FFF_FFFF));

    // Random traffic: mostly in-range operations, some errors and noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_offs_asked++;
      if (n == 300) idle_on = 1'b0;
      if (n == 400) idle_on = 1'b1;
      if (n == 450) pause_until_drained();

      // Size lags by at most one request; a stale pick just lands as a range error.
      size       = list_size;
      sel        = $urandom_range(99);
      r.value    = pick_value();
      r.position = pos_t'($urandom);
      if (sel < 12) begin
        r.mode = MODE_PUSH_FRONT;
      end else if (sel < 24) begin
        r.mode = MODE_PUSH_BACK;
      end else if (sel < 34) begin
        r.mode = MODE_POP_FRONT;
      end else if (sel < 62) begin
        r.mode     = MODE_INSERT;
        r.position = pos_t'($urandom_range(0, size));
      end else if (sel < 88) begin
        r.mode     = MODE_ERASE;
        r.position = (size == 0) ? '0 : pos_t'($urandom_range(0, size - 1));
      end else if (sel < 89) begin
        r.mode = MODE_CLEAR;
      end else if (sel < 92) begin
        r.mode = sel[0] ? MODE_SPARE_7 : MODE_SPARE_6;
      end else if (sel < 96) begin
        r.mode     = MODE_INSERT;
        r.position = pos_t'($urandom_range(size + 1, 127));
      end else begin
        r.mode     = MODE_ERASE;
        r.position = pos_t'($urandom_range(size, 127));
      end
      send_request(r);
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ille_pkg.sv
hw/rtl/ille_dp.sv
hw/rtl/ille_ctrl.sv
hw/rtl/indexed_linked_list_engine.sv
bench/ille_checker.sv
bench/tb_top.sv
